// ----- hdl/unsigned_radix_to_ascii_unit_macros.svh -----
// Assertion macros shared by the checker.
`ifndef UNSIGNED_RADIX_TO_ASCII_UNIT_MACROS_SVH
`define UNSIGNED_RADIX_TO_ASCII_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define URTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define URTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/urta_pkg.sv -----
`default_nettype none

package urta_pkg;

  // Width of the number that is converted.
  localparam int VALUE_BITS = 32;
  // Width of the value field on the input port.
  localparam int VALUE_IN_W = 32;
  localparam int REQ_TYPE_W = 2;
  localparam int CHAR_W     = 7;
  localparam int CHARS_W    = 4;
  localparam int DIGIT_W    = 4;

  // Most digits a number can produce (octal is the longest form).
  localparam int MAX_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  localparam int OUT_TDATA_W = ((CHAR_W + CHARS_W + 7) / 8) * 8;

  // Reciprocal of ten, scaled so that the truncated product is exact over the value range.
  localparam int DEC_SHIFT = VALUE_BITS + 4;
  localparam logic [VALUE_BITS+4:0] DEC_POW      = {1'b1, {(VALUE_BITS + 4){1'b0}}};
  localparam logic [VALUE_BITS+4:0] DEC_MUL_FULL = DEC_POW / 10 + 1;
  localparam logic [VALUE_BITS:0]   DEC_MUL      = DEC_MUL_FULL[VALUE_BITS:0];

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_LO_A = 7'h61;
  localparam logic [CHAR_W-1:0] ASCII_UP_A = 7'h41;

  typedef enum logic [REQ_TYPE_W-1:0] {
    FMT_DEC    = 2'd0,
    FMT_OCT    = 2'd1,
    FMT_HEX_LO = 2'd2,
    FMT_HEX_UP = 2'd3
  } urta_fmt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } urta_state_t;

  // Result of one divide-by-radix step.
  typedef struct packed {
    logic [VALUE_BITS-1:0] quot;
    logic [DIGIT_W-1:0]    rem;
  } urta_div_res_t;

  // Write request into the digit buffer.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [DIGIT_W-1:0] data;
  } urta_buf_wr_t;

  // ASCII code of one digit value.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] letter_base;
    letter_base = upper ? ASCII_UP_A : ASCII_LO_A;
    if (d < 4'd10) begin
      digit_char = ASCII_ZERO + CHAR_W'(d);
    end else begin
      digit_char = letter_base + CHAR_W'(d - 4'd10);
    end
  endfunction

endpackage

`default_nettype wire

// ----- hdl/urta_divstep.sv -----
`default_nettype none

// One division of the working value by the selected radix.
module urta_divstep (
  input  wire urta_pkg::urta_fmt_t              fmt,
  input  wire logic [urta_pkg::VALUE_BITS-1:0]  value,
  output urta_pkg::urta_div_res_t               res
);

  localparam int W = urta_pkg::VALUE_BITS;

  logic [2*W:0] prod;
  logic [W-1:0] dec_quot;
  logic [W-1:0] dec_rem_full;

  // Decimal: multiply by the scaled reciprocal, then recover the remainder.
  always_comb begin
    prod         = (2*W+1)'(value) * (2*W+1)'(urta_pkg::DEC_MUL);
    dec_quot     = W'(prod >> urta_pkg::DEC_SHIFT);
    dec_rem_full = value - (dec_quot << 3) - (dec_quot << 1);
  end

  // Selects the result by format; octal and hex are plain shifts and masks.
  always_comb begin
    case (fmt)
      urta_pkg::FMT_DEC: begin
        res.quot = dec_quot;
        res.rem  = dec_rem_full[urta_pkg::DIGIT_W-1:0];
      end
      urta_pkg::FMT_OCT: begin
        res.quot = value >> 3;
        res.rem  = {1'b0, value[2:0]};
      end
      default: begin
        res.quot = value >> 4;
        res.rem  = value[3:0];
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/urta_digit_buf.sv -----
`default_nettype none

// Holds the digits least significant first until they are sent out in reverse.
module urta_digit_buf (
  input  wire logic                              clk,
  input  wire urta_pkg::urta_buf_wr_t            wr,
  input  wire logic [urta_pkg::IDX_W-1:0]        rd_addr,
  output logic [urta_pkg::DIGIT_W-1:0]           rd_data
);

  logic [urta_pkg::DIGIT_W-1:0] digits_r [urta_pkg::MAX_DIGITS];
  logic [urta_pkg::DIGIT_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      digits_r[wr.addr] <= wr.data;
    end
  end

  // Registered read port; a digit written in the same cycle is passed straight through.
  always_ff @(posedge clk) begin
    if (wr.we && (wr.addr == rd_addr)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= digits_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/unsigned_radix_to_ascii_unit.sv -----
// Unsigned number to ASCII digits, in decimal, octal, lowercase or uppercase hex.
//
// Input channel: in_tdata carries the number, in_tuser the format code
// (0 decimal, 1 octal, 2 lowercase hex, 3 uppercase hex). One item is taken
// at a time; in_tready is high only while the block is idle.
// Output channel: one item per digit, most significant first. out_tdata holds
// the ASCII code and the running character count; out_tlast marks the final digit.
// A zero value gives the single character '0'.
//
// Timing: a number of D digits (1 to 11) is accepted in the idle state, then
// goes through the shared divide-by-radix unit (one digit per cycle), then
// through the output register, one digit per cycle while out_tready allows.
//
// A stall on out_tready holds the current digit and freezes the sequence;
// nothing is lost. The next number is accepted once the last digit has been
// loaded into the output register. Reset (rst_n low, synchronous) returns the
// block to idle and drops any pending output.
`default_nettype none

module unsigned_radix_to_ascii_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // value [31:0]
  input  wire logic [urta_pkg::VALUE_IN_W-1:0]      in_tdata,
  // req_type [1:0]
  input  wire logic [urta_pkg::REQ_TYPE_W-1:0]      in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // char_code [6:0], chars_written [10:7], zero fill above
  output logic [urta_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                      out_tlast
);

  localparam int W = urta_pkg::VALUE_BITS;

  urta_pkg::urta_state_t state_r, state_nxt;
  urta_pkg::urta_fmt_t   fmt_r, fmt_nxt;
  logic [W-1:0]                   val_r, val_nxt;
  logic [urta_pkg::CNT_W-1:0]     ndig_r, ndig_nxt;
  logic [urta_pkg::IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [urta_pkg::CNT_W-1:0]     sent_r, sent_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_last_r, out_last_nxt;
  logic [urta_pkg::CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic [urta_pkg::CHARS_W-1:0]   out_cnt_r, out_cnt_nxt;

  urta_pkg::urta_div_res_t div_res;
  urta_pkg::urta_buf_wr_t  buf_wr;
  logic [urta_pkg::DIGIT_W-1:0] buf_rd;
  logic                         out_free;

  urta_divstep u_divstep (
    .fmt   (fmt_r),
    .value (val_r),
    .res   (div_res)
  );

  // The buffer reads ahead with the next index so its registered data matches rd_idx_r.
  urta_digit_buf u_digit_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_addr (rd_idx_nxt),
    .rd_data (buf_rd)
  );

  assign out_free = !out_valid_r || out_tready;

  // Sequencer: accept, divide until the quotient is zero, then send digits back.
  always_comb begin
    state_nxt     = state_r;
    fmt_nxt       = fmt_r;
    val_nxt       = val_r;
    ndig_nxt      = ndig_r;
    rd_idx_nxt    = rd_idx_r;
    sent_nxt      = sent_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_char_nxt  = out_char_r;
    out_cnt_nxt   = out_cnt_r;
    buf_wr.we     = 1'b0;
    buf_wr.addr   = ndig_r[urta_pkg::IDX_W-1:0];
    buf_wr.data   = div_res.rem;
    in_tready     = 1'b0;

    // The output slot empties when its item is taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      urta_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          val_nxt   = W'(in_tdata);
          fmt_nxt   = urta_pkg::urta_fmt_t'(in_tuser);
          ndig_nxt  = '0;
          state_nxt = urta_pkg::ST_DIV;
        end
      end
      urta_pkg::ST_DIV: begin
        buf_wr.we = 1'b1;
        val_nxt   = div_res.quot;
        ndig_nxt  = ndig_r + 1'b1;
        if (div_res.quot == '0) begin
          rd_idx_nxt = ndig_r[urta_pkg::IDX_W-1:0];
          sent_nxt   = '0;
          state_nxt  = urta_pkg::ST_EMIT;
        end
      end
      urta_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = urta_pkg::digit_char(buf_rd, fmt_r == urta_pkg::FMT_HEX_UP);
          out_last_nxt  = (rd_idx_r == '0);
          out_cnt_nxt   = urta_pkg::CHARS_W'(sent_r + 1'b1);
          sent_nxt      = sent_r + 1'b1;
          if (rd_idx_r == '0) begin
            state_nxt = urta_pkg::ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = urta_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= urta_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    fmt_r      <= fmt_nxt;
    val_r      <= val_nxt;
    ndig_r     <= ndig_nxt;
    rd_idx_r   <= rd_idx_nxt;
    sent_r     <= sent_nxt;
    out_last_r <= out_last_nxt;
    out_char_r <= out_char_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = urta_pkg::OUT_TDATA_W'({out_cnt_r, out_char_r});

endmodule

`default_nettype wire

// ----- hdl/urta_checker.sv -----
`default_nettype none
`include "unsigned_radix_to_ascii_unit_macros.svh"

// Port-level checks on the converter.
module urta_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [urta_pkg::VALUE_IN_W-1:0]  in_tdata,
  input wire logic [urta_pkg::REQ_TYPE_W-1:0]  in_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [urta_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tlast
);

  logic [urta_pkg::CHAR_W-1:0]  chk_char;
  logic [urta_pkg::CHARS_W-1:0] chk_cnt;
  logic                         chk_char_ok;

  // Decode the digit fields and check that the character is a legal digit.
  always_comb begin
    chk_char    = out_tdata[urta_pkg::CHAR_W-1:0];
    chk_cnt     = out_tdata[urta_pkg::CHAR_W+urta_pkg::CHARS_W-1:urta_pkg::CHAR_W];
    chk_char_ok = (chk_char >= 7'h30 && chk_char <= 7'h39) ||
                  (chk_char >= 7'h61 && chk_char <= 7'h66) ||
                  (chk_char >= 7'h41 && chk_char <= 7'h46);
  end

  // A stalled item holds.
  `URTA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output item changed while stalled")

  // Only one number is in work at a time.
  `URTA_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "input accepted again right after an accept")

  // No new number is taken while digits of the current one are still due.
  `URTA_ASSERT_NOW(a_busy_midword, out_tvalid && !out_tlast, !in_tready, "input ready while a number is still being sent")

  // Digits of one number follow back to back, each a legal digit with a nonzero count.
  `URTA_ASSERT_NEXT(a_digits_follow, out_tvalid && out_tready && !out_tlast, out_tvalid && chk_char_ok && chk_cnt != '0, "gap or bad digit inside a number")

endmodule

bind unsigned_radix_to_ascii_unit urta_checker u_urta_checker (.*);

`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_NUMBERS = 200;
  // Margin after the last digit, sized from the longest item (MAX_DIGITS digits).
  localparam int SETTLE_CYCLES  = 4 * urta_pkg::MAX_DIGITS + 8;

  // One expected character on the output channel.
  typedef struct packed {
    logic [urta_pkg::CHAR_W-1:0]  code;
    logic                         last;
    logic [urta_pkg::CHARS_W-1:0] count;
  } ascii_char_t;

  // Predicts the digit string of each accepted number and checks characters in order.
  class digit_scoreboard;
    ascii_char_t expected_q[$];
    int          errors = 0;

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    // Works out the characters of one accepted number, most significant first.
    function void note_number(urta_pkg::urta_fmt_t fmt,
                              logic [urta_pkg::VALUE_IN_W-1:0] value);
      logic [urta_pkg::VALUE_BITS-1:0] n;
      int unsigned                     radix;
      string                           glyphs;
      byte                             lsd_first[$];
      int                              total;
      ascii_char_t                     ch;
      n = value[urta_pkg::VALUE_BITS-1:0];
      case (fmt)
        urta_pkg::FMT_DEC: radix = 10;
        urta_pkg::FMT_OCT: radix = 8;
        default: radix = 16;
      endcase
      glyphs = (fmt == urta_pkg::FMT_HEX_UP) ? "0123456789ABCDEF" : "0123456789abcdef";
      // A zero value still yields one digit.
      do begin
        lsd_first.push_back(glyphs[int'(n % radix)]);
        n = n / radix;
      end while (n != 0);
      total = lsd_first.size();
      for (int k = 0; k < total; k++) begin
        ch.code  = lsd_first[total - 1 - k][urta_pkg::CHAR_W-1:0];
        ch.last  = (k == total - 1);
        ch.count = urta_pkg::CHARS_W'(k + 1);
        expected_q.push_back(ch);
      end
    endfunction

    // Compares one accepted character with the oldest expectation.
    task check_char(logic [urta_pkg::CHAR_W-1:0] code, logic last,
                    logic [urta_pkg::CHARS_W-1:0] count);
      ascii_char_t exp_ch;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("character 0x%0h arrived with nothing expected", code));
        return;
      end
      exp_ch = expected_q.pop_front();
      if (code !== exp_ch.code)
        report_mismatch($sformatf("char_code 0x%0h, expected 0x%0h", code, exp_ch.code));
      if (last !== exp_ch.last)
        report_mismatch($sformatf("tlast %b, expected %b", last, exp_ch.last));
      if (count !== exp_ch.count)
        report_mismatch($sformatf("chars_written %0d, expected %0d", count, exp_ch.count));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [urta_pkg::VALUE_IN_W-1:0]  in_tdata = '0;
  logic [urta_pkg::REQ_TYPE_W-1:0]  in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [urta_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;

  // When set, neither side inserts idle cycles.
  bit               no_idle = 1'b0;
  int               quiet_cycles = 0;
  digit_scoreboard  sb = new();

  unsigned_radix_to_ascii_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // Offers one number after a random gap and returns at the accepting edge.
  task automatic send_number(urta_pkg::urta_fmt_t fmt,
                             logic [urta_pkg::VALUE_IN_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= fmt;
    do @(posedge clk); while (!in_tready);
    sb.note_number(fmt, value);
  endtask

  // Holds the input off until every expected character has come out.
  task automatic drain_output();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: random stall before each character, then take it and check it.
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_char(out_tdata[urta_pkg::CHAR_W-1:0], out_tlast,
                    out_tdata[urta_pkg::CHAR_W+urta_pkg::CHARS_W-1:urta_pkg::CHAR_W]);
    end
  end

  // Ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: reset, directed corners, then random numbers in phases.
  initial begin
    int                              width;
    logic [urta_pkg::VALUE_IN_W-1:0] value;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero and all ones in every format; all ones in octal is the longest string.
    for (int f = 0; f < 4; f++) begin
      send_number(urta_pkg::urta_fmt_t'(f), '0);
      send_number(urta_pkg::urta_fmt_t'(f), '1);
    end
    // Digit rollover points for each radix.
    send_number(urta_pkg::FMT_DEC, 32'd9);
    send_number(urta_pkg::FMT_DEC, 32'd10);
    send_number(urta_pkg::FMT_DEC, 32'd999999999);
    send_number(urta_pkg::FMT_DEC, 32'd1000000000);
    send_number(urta_pkg::FMT_OCT, 32'o7);
    send_number(urta_pkg::FMT_OCT, 32'o10);
    send_number(urta_pkg::FMT_OCT, 32'h8000_0000);
    send_number(urta_pkg::FMT_HEX_LO, 32'hF);
    send_number(urta_pkg::FMT_HEX_UP, 32'h10);
    // Every letter digit in both cases.
    send_number(urta_pkg::FMT_HEX_LO, 32'hABCD_EF01);
    send_number(urta_pkg::FMT_HEX_UP, 32'hABCD_EF01);
    send_number(urta_pkg::FMT_HEX_UP, 32'h0FED_CBA9);
    drain_output();

    // Random numbers, each masked to a random number of low bits.
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i % 55 == 0)
        no_idle = (i / 55 == 1) || ($urandom_range(0, 3) == 0);
      if (i == RANDOM_NUMBERS / 2)
        drain_output();
      width = $urandom_range(1, urta_pkg::VALUE_IN_W);
      value = $urandom & ({urta_pkg::VALUE_IN_W{1'b1}} >> (urta_pkg::VALUE_IN_W - width));
      send_number(urta_pkg::urta_fmt_t'($urandom_range(0, 3)), value);
    end
    drain_output();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
